@@ sv/nwss_pkg.sv @@
// Shared types and constants for the nose wheel steering slew control unit.
`default_nettype none

package nwss_pkg;

   localparam int AUTH_W  = 15;
   localparam int SPEED_W = 16;
   localparam int RATIO_W = 16;
   localparam int ANGLE_W = 19;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic signed [ANGLE_W-1:0] STEER_LIMIT = 19'sd163840;

   localparam logic [AUTH_W-1:0]  AUTH_STEP_RESET  = 15'd1280;
   localparam logic [AUTH_W-1:0]  AUTH_MAX_RESET   = 15'd16128;
   localparam logic [AUTH_W-1:0]  AUTH_MIN_RESET   = 15'd3072;
   localparam logic [AUTH_W-1:0]  STEER_STEP_RESET = 15'd128;
   localparam logic [AUTH_W-1:0]  SNAP_BAND_RESET  = 15'd154;
   localparam logic [SPEED_W-1:0] PROP_LIMIT_RESET = 16'd1872;

   localparam logic [AUTH_W-1:0]  AUTHORITY_RESET  = 15'd3072;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_AUTH_STEP  = 3'd0,
      CSR_AUTH_MAX   = 3'd1,
      CSR_AUTH_MIN   = 3'd2,
      CSR_STEER_STEP = 3'd3,
      CSR_SNAP_BAND  = 3'd4,
      CSR_PROP_LIMIT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ARM_OFF   = 2'd0,
      ARM_ON    = 2'd1,
      ARM_CHECK = 2'd2
   } arm_mode_type;

   typedef enum logic [1:0] {
      RESCHED_SLOW  = 2'd0,
      RESCHED_ARMED = 2'd1,
      RESCHED_SLEW  = 2'd2
   } resched_type;

   typedef struct packed {
      logic [AUTH_W-1:0]  authority_step;
      logic [AUTH_W-1:0]  authority_max;
      logic [AUTH_W-1:0]  authority_min;
      logic [AUTH_W-1:0]  steer_step;
      logic [AUTH_W-1:0]  snap_band;
      logic [SPEED_W-1:0] prop_speed_limit;
   } cfg_type;

   typedef struct packed {
      logic                      gear_down;
      logic [1:0]                arm_mode;
      logic                      park_on;
      logic                      engage_sw;
      logic signed [RATIO_W-1:0] heading_ratio;
      logic [SPEED_W-1:0]        prop_speed;
   } item_type;

   typedef struct packed {
      logic [AUTH_W-1:0]         authority;
      logic signed [ANGLE_W-1:0] steer;
      logic                      enabled;
   } state_type;

   typedef struct packed {
      logic                      steering_enabled;
      logic signed [ANGLE_W-1:0] steer_angle;
      logic [AUTH_W-1:0]         authority_now;
      logic [1:0]                reschedule_code;
   } result_type;

endpackage

`default_nettype wire

@@ sv/nose_wheel_steering_slew_control_unit.sv @@
// Top level of the nose wheel steering slew control unit.
// Each item is one control tick. An accepted item lands in an input register; when
// the output register is free or being drained, the authority ramp, the
// ratio-times-authority multiply and the steer slew are evaluated in one pass, the
// state registers are updated and the result is loaded into the output register.
// The block sustains one item per clock cycle while rsp_tready is held high; a
// result is held in the output register until it is taken. The rate is set by the
// state loop through the multiplier and the slew adder. Configuration registers
// take effect on the next item after the write.
`default_nettype none

module nose_wheel_steering_slew_control_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // gear_down[0], arm_mode[2:1], park_on[3], engage_sw[4], heading_ratio[20:5],
   // prop_speed[36:21], zero fill [39:37]
   input  wire logic [nwss_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // steering_enabled[0], steer_angle[19:1], authority_now[34:20],
   // reschedule_code[36:35], zero fill [39:37]
   output      logic [nwss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_we,
   input  wire logic [nwss_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [nwss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nwss_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_fire;
   logic       advance;

   nwss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nwss_core u_core (
      .cfg        (cfg),
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   assign req_item.gear_down     = req_tdata[0];
   assign req_item.arm_mode      = req_tdata[2:1];
   assign req_item.park_on       = req_tdata[3];
   assign req_item.engage_sw     = req_tdata[4];
   assign req_item.heading_ratio = $signed(req_tdata[20:5]);
   assign req_item.prop_speed    = req_tdata[36:21];

   // The held item is processed when the output register is free or being drained.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.authority <= AUTHORITY_RESET;
         state_ff.steer     <= '0;
         state_ff.enabled   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff.reschedule_code, result_ff.authority_now,
                        result_ff.steer_angle, result_ff.steering_enabled};

   // The steer angle register never leaves the saturation range.
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.steer <= STEER_LIMIT) && (state_ff.steer >= -STEER_LIMIT))
      else $error("steer angle outside saturation range");

   // Without a processed item the steering state must not move.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("steering state changed without an item");

   // The slow reschedule code is only given when unarmed, which clears the flag.
   a_slow_code_disabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.reschedule_code == RESCHED_SLOW))
      |-> !result_ff.steering_enabled)
      else $error("enabled flag set with unarmed reschedule code");

   // A result register that is being loaded must have been free or drained.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ sv/nwss_csr.sv @@
// Configuration register file of the nose wheel steering slew control unit.
`default_nettype none

module nwss_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [nwss_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [nwss_pkg::CSR_DATA_W-1:0] csr_wdata,
   output nwss_pkg::cfg_type                    cfg
);
   import nwss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_AUTH_STEP:  cfg_in.authority_step   = csr_wdata[AUTH_W-1:0];
            CSR_AUTH_MAX:   cfg_in.authority_max    = csr_wdata[AUTH_W-1:0];
            CSR_AUTH_MIN:   cfg_in.authority_min    = csr_wdata[AUTH_W-1:0];
            CSR_STEER_STEP: cfg_in.steer_step       = csr_wdata[AUTH_W-1:0];
            CSR_SNAP_BAND:  cfg_in.snap_band        = csr_wdata[AUTH_W-1:0];
            CSR_PROP_LIMIT: cfg_in.prop_speed_limit = csr_wdata[SPEED_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.authority_step   <= AUTH_STEP_RESET;
         cfg_ff.authority_max    <= AUTH_MAX_RESET;
         cfg_ff.authority_min    <= AUTH_MIN_RESET;
         cfg_ff.steer_step       <= STEER_STEP_RESET;
         cfg_ff.snap_band        <= SNAP_BAND_RESET;
         cfg_ff.prop_speed_limit <= PROP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/nwss_core.sv @@
// Single-pass update of authority, command and steer angle for one control tick.
`default_nettype none

module nwss_core (
   input  wire nwss_pkg::cfg_type    cfg,
   input  wire nwss_pkg::item_type   item,
   input  wire nwss_pkg::state_type  state,
   output nwss_pkg::state_type       state_next,
   output nwss_pkg::result_type      result
);
   import nwss_pkg::*;

   localparam logic signed [ANGLE_W:0] LIMIT_W = {STEER_LIMIT[ANGLE_W-1], STEER_LIMIT};

   logic                      armed;
   logic                      drive;
   logic [AUTH_W:0]           auth_up;
   logic signed [AUTH_W+1:0]  auth_dn;
   logic [AUTH_W-1:0]         auth_next;
   logic signed [31:0]        prod;
   logic signed [33:0]        prod5;
   logic signed [ANGLE_W:0]   quot;
   logic signed [ANGLE_W-1:0] cmd_sat;
   logic signed [ANGLE_W-1:0] cmd;
   logic signed [ANGLE_W:0]   diff;
   logic signed [ANGLE_W:0]   band;
   logic signed [ANGLE_W:0]   steer_w;
   logic signed [ANGLE_W:0]   step_w;
   logic signed [ANGLE_W:0]   steer_new;
   logic signed [ANGLE_W-1:0] steer_sat;
   logic                      snap;
   logic [1:0]                code;
   logic                      enabled_next;

   assign armed = item.gear_down && (item.arm_mode == ARM_ON);
   assign drive = item.engage_sw || (item.prop_speed < cfg.prop_speed_limit);

   // While armed, authority walks toward the selected limit and stops there; a value
   // already past that limit, or any value while unarmed, is left where it is.
   always_comb begin
      auth_up   = {1'b0, state.authority} + {1'b0, cfg.authority_step};
      auth_dn   = $signed({2'b00, state.authority}) - $signed({2'b00, cfg.authority_step});
      auth_next = state.authority;
      if (armed) begin
         if (item.park_on && (state.authority < cfg.authority_max)) begin
            auth_next = (auth_up > {1'b0, cfg.authority_max}) ?
                        cfg.authority_max : auth_up[AUTH_W-1:0];
         end else if (!item.park_on && (state.authority > cfg.authority_min)) begin
            auth_next = (auth_dn < $signed({2'b00, cfg.authority_min})) ?
                        cfg.authority_min : auth_dn[AUTH_W-1:0];
         end
      end
   end

   // The arithmetic shift of the scaled product gives the floored quotient.
   assign prod  = item.heading_ratio * $signed({1'b0, auth_next});
   assign prod5 = {{2{prod[31]}}, prod} + {prod, 2'b00};
   assign quot  = prod5[33:14];

   always_comb begin
      if (quot > LIMIT_W) begin
         cmd_sat = STEER_LIMIT;
      end else if (quot < -LIMIT_W) begin
         cmd_sat = -STEER_LIMIT;
      end else begin
         cmd_sat = quot[ANGLE_W-1:0];
      end
   end

   assign cmd = (armed && drive) ? cmd_sat : '0;

   always_comb begin
      if (!armed) begin
         enabled_next = 1'b0;
      end else if (drive) begin
         enabled_next = 1'b1;
      end else begin
         enabled_next = state.enabled;
      end
   end

   assign steer_w = {state.steer[ANGLE_W-1], state.steer};
   assign step_w  = $signed({{(ANGLE_W-AUTH_W+1){1'b0}}, cfg.steer_step});
   assign band    = $signed({{(ANGLE_W-AUTH_W+1){1'b0}}, cfg.snap_band});
   assign diff    = {cmd[ANGLE_W-1], cmd} - steer_w;
   assign snap    = (diff < band) && (diff > -band);

   always_comb begin
      code      = armed ? RESCHED_ARMED : RESCHED_SLOW;
      steer_new = steer_w;
      if (snap) begin
         steer_new = {cmd[ANGLE_W-1], cmd};
      end else if (diff < 0) begin
         steer_new = steer_w - step_w;
         code      = RESCHED_SLEW;
      end else if (diff > 0) begin
         steer_new = steer_w + step_w;
         code      = RESCHED_SLEW;
      end
   end

   always_comb begin
      if (steer_new > LIMIT_W) begin
         steer_sat = STEER_LIMIT;
      end else if (steer_new < -LIMIT_W) begin
         steer_sat = -STEER_LIMIT;
      end else begin
         steer_sat = steer_new[ANGLE_W-1:0];
      end
   end

   assign state_next.authority = auth_next;
   assign state_next.steer     = steer_sat;
   assign state_next.enabled   = enabled_next;

   assign result.steering_enabled = enabled_next;
   assign result.steer_angle      = steer_sat;
   assign result.authority_now    = auth_next;
   assign result.reschedule_code  = code;

endmodule

`default_nettype wire
